[rtl/positional_list_engine_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the positional list engine
// Shared concurrent checks, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PLE_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PLE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/ple_pkg.sv]
// ---------------------------------------------------------------------------
// ple_pkg
// Widths, codes and types shared by the positional list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int ST_W     = 3;
  localparam int LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_BELOW_ONE    = 3'd1,
    ST_OUT_OF_BOUND = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  item_value;
    logic        [LEN_W-1:0]   length;
  } result_t;

endpackage

[rtl/ple_if.sv]
// ---------------------------------------------------------------------------
// ple_if
// Valid/ready channels for command and response words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ple_in_if;
  logic                              valid;
  logic                              ready;
  logic        [ple_pkg::OP_W-1:0]   op;
  logic signed [ple_pkg::DATA_W-1:0] value;
  logic        [ple_pkg::POS_W-1:0]  position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

interface ple_out_if;
  logic                              valid;
  logic                              ready;
  logic        [ple_pkg::ST_W-1:0]   status;
  logic signed [ple_pkg::DATA_W-1:0] item_value;
  logic        [ple_pkg::LEN_W-1:0]  length;

  modport source (output valid, status, item_value, length, input ready);
  modport sink   (input valid, status, item_value, length, output ready);
endinterface

[rtl/positional_list_engine.sv]
// ---------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with positional insert/delete.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one command word (op, value, position); rsp returns one word
//   per command (status, item_value, length). Both are valid/ready.
//   A command is taken only while the sequencer is idle. It passes through
//   the bounds check, then sweeps the n entries from the touched place to
//   the end through the entry memory, one entry per cycle (one read port,
//   one write port, registered read), then drains the last read and, for an
//   insert, writes the new value. An insert with nothing to move does only
//   that final write.
//   The sequencer returns to idle only once its response is taken, so a new
//   command is not accepted before the last one is through; n is CAPACITY
//   at most.
//   Reset clears the length; entry contents are left as they are and are
//   never read beyond the length, so no clearing pass runs.
//   A finished response sits in the output register; a new command may be
//   accepted meanwhile. A stalled rsp holds the sequencer at its final step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  ple_in_if.sink   cmd,
  ple_out_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic                          res_valid;
  logic                          res_take;
  ple_pkg::result_t              res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [ple_pkg::DATA_W-1:0]    ram_wdata;
  logic [ple_pkg::DATA_W-1:0]    ram_rdata;
  logic                          out_valid;
  ple_pkg::result_t              out_word;
  logic                          res_err;

  ple_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ple_ram #(
    .WIDTH (ple_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_word.status;
  assign rsp.item_value = out_word.item_value;
  assign rsp.length     = out_word.length;

  assign res_err = res_valid && (res.status != ple_pkg::ST_OK);

  `PLE_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
  `PLE_ASSERT_IMPL(a_err_item_zero, clk, rst, res_err, res.item_value == '0)
  `PLE_ASSERT_NEXT(a_result_loaded, clk, rst, res_take, rsp.valid && rsp.status == $past(res.status))

endmodule

[rtl/ple_ram.sv]
// ---------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ram #(
  parameter int WIDTH = ple_pkg::DATA_W,
  parameter int DEPTH = ple_pkg::CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ple_seq.sv]
// ---------------------------------------------------------------------------
// ple_seq
// Command sequencer: bounds check, then a pipelined read/write sweep that
// moves entries one slot per cycle through the entry memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_seq #(
  parameter int CAPACITY = ple_pkg::CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  ple_in_if.sink                         cmd,
  output logic                           res_valid,
  output ple_pkg::result_t               res,
  input  logic                           res_take,
  output logic                           ram_we,
  output logic [$clog2(CAPACITY)-1:0]    ram_waddr,
  output logic [ple_pkg::DATA_W-1:0]     ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]    ram_raddr,
  input  logic [ple_pkg::DATA_W-1:0]     ram_rdata
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  ple_pkg::state_t                   state, state_next;
  ple_pkg::op_t                      op;
  logic signed [ple_pkg::DATA_W-1:0] val;
  logic        [ple_pkg::POS_W-1:0]  pos;
  logic        [CW-1:0]              cnt;
  logic        [AW-1:0]              k;
  logic        [CW-1:0]              left;
  logic        [AW-1:0]              rd_addr;
  logic                              first;
  logic                              pend;
  logic                              pend_first;
  logic        [AW-1:0]              pend_addr;
  ple_pkg::status_t                  status;
  logic signed [ple_pkg::DATA_W-1:0] item;

  logic              is_ins, is_del, full, empty, issue, finish;
  logic [CMPW-1:0]   pos_x, cnt_x;
  ple_pkg::status_t  chk_status;
  logic [AW-1:0]     chk_k;

  assign pos_x  = CMPW'(pos);
  assign cnt_x  = CMPW'(cnt);
  assign full   = (cnt == CW'(CAPACITY));
  assign empty  = (cnt == '0);
  assign is_ins = (op == ple_pkg::OP_INS_FRONT) || (op == ple_pkg::OP_INS_BACK) ||
                  (op == ple_pkg::OP_INS_POS);
  assign is_del = (op == ple_pkg::OP_DEL_FRONT) || (op == ple_pkg::OP_DEL_BACK) ||
                  (op == ple_pkg::OP_DEL_POS);
  assign issue  = (left != '0);
  assign finish = !issue && !pend;

  // bounds check on the latched command
  always_comb begin
    chk_status = ple_pkg::ST_OK;
    chk_k      = '0;
    unique case (op)
      ple_pkg::OP_INS_FRONT: begin
        if (full) chk_status = ple_pkg::ST_FULL;
      end
      ple_pkg::OP_INS_BACK: begin
        if (full) chk_status = ple_pkg::ST_FULL;
        chk_k = AW'(cnt);
      end
      ple_pkg::OP_INS_POS: begin
        if (pos_x == '0)               chk_status = ple_pkg::ST_BELOW_ONE;
        else if (pos_x > cnt_x + 1'b1) chk_status = ple_pkg::ST_OUT_OF_BOUND;
        else if (full)                 chk_status = ple_pkg::ST_FULL;
        chk_k = AW'(pos_x - 1'b1);
      end
      ple_pkg::OP_DEL_FRONT: begin
        if (empty) chk_status = ple_pkg::ST_EMPTY;
      end
      ple_pkg::OP_DEL_BACK: begin
        if (empty) chk_status = ple_pkg::ST_EMPTY;
        chk_k = AW'(cnt - 1'b1);
      end
      ple_pkg::OP_DEL_POS: begin
        if (pos_x == '0)       chk_status = ple_pkg::ST_BELOW_ONE;
        else if (empty)        chk_status = ple_pkg::ST_EMPTY;
        else if (pos_x > cnt_x) chk_status = ple_pkg::ST_OUT_OF_BOUND;
        chk_k = AW'(pos_x - 1'b1);
      end
      default: begin
        chk_status = ple_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = pend_addr;
    ram_wdata  = ram_rdata;
    ram_raddr  = rd_addr;
    unique case (state)
      ple_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) state_next = ple_pkg::S_CHECK;
      end
      ple_pkg::S_CHECK: begin
        if (chk_status != ple_pkg::ST_OK || !(is_ins || is_del)) begin
          state_next = ple_pkg::S_DONE;
        end else begin
          state_next = ple_pkg::S_SHIFT;
        end
      end
      ple_pkg::S_SHIFT: begin
        ram_we = pend && !pend_first;
        if (finish) begin
          if (is_ins) begin
            ram_we    = 1'b1;
            ram_waddr = k;
            ram_wdata = val;
          end
          state_next = ple_pkg::S_DONE;
        end
      end
      ple_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) state_next = ple_pkg::S_IDLE;
      end
      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      unique case (state)
        ple_pkg::S_IDLE: begin
          pend <= 1'b0;
        end
        ple_pkg::S_SHIFT: begin
          pend <= issue;
          if (finish) cnt <= is_ins ? CW'(cnt + 1'b1) : CW'(cnt - 1'b1);
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  // payload and sweep registers
  always_ff @(posedge clk) begin
    if (state == ple_pkg::S_IDLE && cmd.valid) begin
      op  <= ple_pkg::op_t'(cmd.op);
      val <= cmd.value;
      pos <= cmd.position;
    end
    if (state == ple_pkg::S_CHECK) begin
      status  <= chk_status;
      item    <= (chk_status == ple_pkg::ST_OK && is_ins) ? val : '0;
      k       <= chk_k;
      left    <= CW'(cnt - CW'(chk_k));
      rd_addr <= is_ins ? AW'(cnt - 1'b1) : chk_k;
      first   <= is_del;
    end
    if (state == ple_pkg::S_SHIFT) begin
      if (issue) begin
        left       <= CW'(left - 1'b1);
        rd_addr    <= is_ins ? AW'(rd_addr - 1'b1) : AW'(rd_addr + 1'b1);
        pend_addr  <= is_ins ? AW'(rd_addr + 1'b1) : AW'(rd_addr - 1'b1);
        pend_first <= first;
        first      <= 1'b0;
      end
      if (pend && pend_first) item <= ram_rdata;
    end
  end

  assign res.status     = status;
  assign res.item_value = item;
  assign res.length     = ple_pkg::LEN_W'(cnt);

endmodule
